// ----- sv/time_of_day_clock_with_alarm_unit_macros.svh -----
// Assertion macros shared by the time-of-day clock checker.
// No dependencies; included by every file that carries assertions.
`ifndef TIME_OF_DAY_CLOCK_WITH_ALARM_UNIT_MACROS_SVH
`define TIME_OF_DAY_CLOCK_WITH_ALARM_UNIT_MACROS_SVH

// Plain clocked assertion, disabled while reset is high
`define TOD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on the following edge
`define TOD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tod_pkg.sv -----
// Types, codes and constants for the time-of-day clock with alarm.
// No dependencies; used by the engine, the top level and the checker.
`default_nettype none

package tod_pkg;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET_CLOCK = 2'd1,
    CMD_SET_ALARM = 2'd2,
    CMD_SILENCE   = 2'd3
  } cmd_t;

  localparam int unsigned TPS_W    = 16;
  localparam int unsigned SET_W    = 7;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 24;

  localparam logic [SEC_W-1:0]  LAST_SECOND = 6'd59;
  localparam logic [MIN_W-1:0]  LAST_MINUTE = 6'd59;
  localparam logic [HOUR_W-1:0] LAST_HOUR   = 5'd23;
  localparam logic [HOUR_W-1:0] NOON_HOUR   = 5'd11;

  typedef struct packed {
    cmd_t             cmd;
    logic [SET_W-1:0] set_hour;
    logic [SET_W-1:0] set_minute;
    logic [SET_W-1:0] set_second;
  } item_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              pm;
    logic              alarm_active;
    logic              set_valid;
  } result_t;

  // hour, minute, second, pm, alarm_active, set_valid from bit 0 up
  function automatic logic [M_TDATA_W-1:0] pack_result(input result_t r);
    return {4'b0000, r.set_valid, r.alarm_active, r.pm, r.second, r.minute, r.hour};
  endfunction

endpackage

`default_nettype wire

// ----- sv/tod_engine.sv -----
// Clock and alarm state with the one-pass update for a single item.
// Depends on tod_pkg.
`default_nettype none

module tod_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       proc,
  input  wire tod_pkg::item_t             item,
  input  wire logic [tod_pkg::TPS_W-1:0]  tps,
  output tod_pkg::result_t                res
);
  import tod_pkg::*;

  logic [TPS_W-1:0]  tick_count, tick_count_next;
  logic [SEC_W-1:0]  clock_second, clock_second_next;
  logic [MIN_W-1:0]  clock_minute, clock_minute_next;
  logic [HOUR_W-1:0] clock_hour, clock_hour_next;
  logic              clock_pm, clock_pm_next;
  logic [SEC_W-1:0]  alarm_second, alarm_second_next;
  logic [MIN_W-1:0]  alarm_minute, alarm_minute_next;
  logic [HOUR_W-1:0] alarm_hour, alarm_hour_next;
  logic              alarm_flag, alarm_flag_next;
  logic              set_valid;

  logic [TPS_W:0]    count_inc;
  logic              full_second;
  logic [SEC_W-1:0]  sec_adv;
  logic [MIN_W-1:0]  min_adv;
  logic [HOUR_W-1:0] hour_adv;
  logic              pm_adv;
  logic              in_range;

  // one-second carry chain
  always_comb begin
    count_inc   = {1'b0, tick_count} + {{TPS_W{1'b0}}, 1'b1};
    full_second = (count_inc >= {1'b0, tps});
    sec_adv     = clock_second;
    min_adv     = clock_minute;
    hour_adv    = clock_hour;
    pm_adv      = clock_pm;
    if (clock_second == LAST_SECOND) begin
      sec_adv = '0;
      if (clock_minute == LAST_MINUTE) begin
        min_adv  = '0;
        hour_adv = (clock_hour == LAST_HOUR) ? '0 : clock_hour + 5'd1;
        pm_adv   = (hour_adv > NOON_HOUR);
      end else begin
        min_adv = clock_minute + 6'd1;
      end
    end else begin
      sec_adv = clock_second + 6'd1;
    end
    in_range = (item.set_hour <= {2'b00, LAST_HOUR}) &&
               (item.set_minute <= {1'b0, LAST_MINUTE}) &&
               (item.set_second <= {1'b0, LAST_SECOND});
  end

  always_comb begin
    tick_count_next   = tick_count;
    clock_second_next = clock_second;
    clock_minute_next = clock_minute;
    clock_hour_next   = clock_hour;
    clock_pm_next     = clock_pm;
    alarm_second_next = alarm_second;
    alarm_minute_next = alarm_minute;
    alarm_hour_next   = alarm_hour;
    alarm_flag_next   = alarm_flag;
    set_valid         = 1'b1;
    case (item.cmd)
      CMD_TICK: begin
        if (full_second) begin
          tick_count_next   = '0;
          clock_second_next = sec_adv;
          clock_minute_next = min_adv;
          clock_hour_next   = hour_adv;
          clock_pm_next     = pm_adv;
          if (hour_adv == alarm_hour && min_adv == alarm_minute &&
              sec_adv == alarm_second) begin
            alarm_flag_next = 1'b1;
          end
        end else begin
          tick_count_next = count_inc[TPS_W-1:0];
        end
      end
      CMD_SET_CLOCK: begin
        if (in_range) begin
          clock_hour_next   = item.set_hour[HOUR_W-1:0];
          clock_minute_next = item.set_minute[MIN_W-1:0];
          clock_second_next = item.set_second[SEC_W-1:0];
          clock_pm_next     = (item.set_hour[HOUR_W-1:0] > NOON_HOUR);
        end else begin
          set_valid = 1'b0;
        end
      end
      CMD_SET_ALARM: begin
        if (in_range) begin
          alarm_hour_next   = item.set_hour[HOUR_W-1:0];
          alarm_minute_next = item.set_minute[MIN_W-1:0];
          alarm_second_next = item.set_second[SEC_W-1:0];
        end else begin
          set_valid = 1'b0;
        end
      end
      CMD_SILENCE: begin
        alarm_flag_next = 1'b0;
      end
      default: begin
        set_valid = 1'b1;
      end
    endcase
  end

  always_comb begin
    res.hour         = clock_hour_next;
    res.minute       = clock_minute_next;
    res.second       = clock_second_next;
    res.pm           = clock_pm_next;
    res.alarm_active = alarm_flag_next;
    res.set_valid    = set_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      clock_second <= '0;
      clock_minute <= '0;
      clock_hour   <= '0;
      clock_pm     <= 1'b0;
      alarm_second <= '0;
      alarm_minute <= '0;
      alarm_hour   <= '0;
      alarm_flag   <= 1'b0;
    end else if (proc) begin
      tick_count   <= tick_count_next;
      clock_second <= clock_second_next;
      clock_minute <= clock_minute_next;
      clock_hour   <= clock_hour_next;
      clock_pm     <= clock_pm_next;
      alarm_second <= alarm_second_next;
      alarm_minute <= alarm_minute_next;
      alarm_hour   <= alarm_hour_next;
      alarm_flag   <= alarm_flag_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/time_of_day_clock_with_alarm_unit.sv -----
// Top level of the time-of-day clock with alarm: input register, engine, result register.
// Depends on tod_pkg and tod_engine.
//
// Usage:
//   s_* stream carries one item per transfer: a tick or a command in s_tuser and the
//   time for set commands in s_tdata. Every item yields exactly one result on m_*,
//   showing hour, minute, second, pm, the alarm flag and whether a set was in range.
//   cfg_* writes ticks_per_second; it is always ready and is meant for idle periods.
//   Path: each item is held in the input register, then its result in the result register.
//   Throughput: one item per cycle while the receiver accepts results, limited only by the
//   single pass through the carry chain and alarm compare.
//   When the receiver stalls, the result register holds and one more item waits in the
//   input register; s_tready drops only when both are full.
//   Reset clears the time, the alarm time, the alarm flag and the tick prescaler, sets
//   ticks_per_second to 1 and empties both registers.
`default_nettype none

module time_of_day_clock_with_alarm_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // set_hour, set_minute, set_second from bit 0 up, zero padded
  input  wire logic [tod_pkg::S_TDATA_W-1:0]  s_tdata,
  // cmd
  input  wire logic [tod_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // hour, minute, second, pm, alarm_active, set_valid from bit 0 up, zero padded
  output logic [tod_pkg::M_TDATA_W-1:0]       m_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tod_pkg::TPS_W-1:0]      cfg_data
);
  import tod_pkg::*;

  logic             in_valid;
  item_t            in_item;
  logic             advance;
  logic             proc;
  logic [TPS_W-1:0] ticks_per_second;
  result_t          res;

  assign advance   = !m_tvalid || m_tready;
  assign proc      = in_valid && advance;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // capture the payload on every input transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd        <= cmd_t'(s_tuser);
      in_item.set_hour   <= s_tdata[SET_W-1:0];
      in_item.set_minute <= s_tdata[2*SET_W-1:SET_W];
      in_item.set_second <= s_tdata[3*SET_W-1:2*SET_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      ticks_per_second <= cfg_data;
    end
  end

  tod_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .proc (proc),
    .item (in_item),
    .tps  (ticks_per_second),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      m_tdata <= pack_result(res);
    end
  end

endmodule

`default_nettype wire

// ----- sv/tod_checker.sv -----
// Port-level checks for the time-of-day clock, bound to the top level.
// Depends on tod_pkg and the assertion macros header.
`default_nettype none
`include "time_of_day_clock_with_alarm_unit_macros.svh"

module tod_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [tod_pkg::M_TDATA_W-1:0] m_tdata
);
  import tod_pkg::*;

  logic [HOUR_W-1:0]  out_hour;
  logic [MIN_W-1:0]   out_minute;
  logic [SEC_W-1:0]   out_second;
  logic               out_pm;
  logic               time_ok;
  logic               pm_ok;
  logic               stalled;
  logic               in_xfer;
  logic [M_TDATA_W:0] out_word;

  assign out_hour   = m_tdata[HOUR_W-1:0];
  assign out_minute = m_tdata[HOUR_W+MIN_W-1:HOUR_W];
  assign out_second = m_tdata[HOUR_W+MIN_W+SEC_W-1:HOUR_W+MIN_W];
  assign out_pm     = m_tdata[HOUR_W+MIN_W+SEC_W];
  assign time_ok    = (out_hour <= LAST_HOUR) && (out_minute <= LAST_MINUTE) &&
                      (out_second <= LAST_SECOND);
  assign pm_ok      = (out_pm == (out_hour > NOON_HOUR));
  assign stalled    = m_tvalid && !m_tready;
  assign in_xfer    = s_tvalid && s_tready;
  assign out_word   = {m_tvalid, m_tdata};

  `TOD_ASSERT(a_time_range, clk, rst, !m_tvalid || time_ok, "time out of range")
  `TOD_ASSERT(a_pm_follows_hour, clk, rst, !m_tvalid || pm_ok, "pm disagrees with hour")
  `TOD_ASSERT_NEXT(a_stall_holds, clk, rst, stalled, $stable(out_word), "stall not held")
  `TOD_ASSERT_NEXT(a_result_due, clk, rst, in_xfer ##1 m_tready, m_tvalid, "result missing")

endmodule

bind time_of_day_clock_with_alarm_unit tod_checker u_tod_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/sv/time_of_day_clock_with_alarm_unit_tb.sv -----
// Self-checking bench for the time-of-day clock with alarm: directed table, then random phases.
// Depends on tod_pkg and time_of_day_clock_with_alarm_unit; results checked against a local model.
`default_nettype none

module time_of_day_clock_with_alarm_unit_tb;
  import tod_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned PHASE_ITEMS   = 130;
  localparam int unsigned SQUEEZE_AT    = 300;
  localparam int unsigned SQUEEZE_LEN   = 80;
  localparam int unsigned DRAIN_CYCLES  = 4;

  typedef enum logic {ROW_ITEM, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    cmd_t             cmd;
    logic [SET_W-1:0] h;
    logic [SET_W-1:0] m;
    logic [SET_W-1:0] s;
    logic [TPS_W-1:0] tps;
    bit               typed;
    result_t          want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [TPS_W-1:0]     cfg_data = '0;

  // local copy of the clock state
  logic [TPS_W-1:0]  ticks_per_sec = 16'd1;
  logic [TPS_W-1:0]  prescale_count = '0;
  logic [HOUR_W-1:0] now_hour = '0;
  logic [MIN_W-1:0]  now_min = '0;
  logic [SEC_W-1:0]  now_sec = '0;
  logic              now_pm = 1'b0;
  logic [HOUR_W-1:0] alm_hour = '0;
  logic [MIN_W-1:0]  alm_min = '0;
  logic [SEC_W-1:0]  alm_sec = '0;
  logic              alarm_on = 1'b0;

  result_t     pending_results[$];
  dir_row_t    dir_table[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned squeeze_left = 0;
  bit          squeeze_done = 1'b0;
  bit          steady = 1'b0;

  time_of_day_clock_with_alarm_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic result_t predict_step(input item_t it);
    result_t     r;
    logic [16:0] next_count;
    logic        in_range;
    in_range = (it.set_hour <= 7'(LAST_HOUR)) && (it.set_minute <= 7'(LAST_MINUTE)) &&
               (it.set_second <= 7'(LAST_SECOND));
    r.set_valid = 1'b1;
    case (it.cmd)
      CMD_TICK: begin
        next_count = {1'b0, prescale_count} + 17'd1;
        if (next_count >= {1'b0, ticks_per_sec}) begin
          prescale_count = '0;
          // carry seconds into minutes into hours, wrap at midnight
          if (now_sec == LAST_SECOND) begin
            now_sec = '0;
            if (now_min == LAST_MINUTE) begin
              now_min  = '0;
              now_hour = (now_hour == LAST_HOUR) ? '0 : now_hour + 5'd1;
              now_pm   = now_hour > NOON_HOUR;
            end else begin
              now_min = now_min + 6'd1;
            end
          end else begin
            now_sec = now_sec + 6'd1;
          end
          if (now_hour == alm_hour && now_min == alm_min && now_sec == alm_sec)
            alarm_on = 1'b1;
        end else begin
          prescale_count = next_count[TPS_W-1:0];
        end
      end
      CMD_SET_CLOCK, CMD_SET_ALARM: begin
        if (!in_range) begin
          r.set_valid = 1'b0;
        end else if (it.cmd == CMD_SET_CLOCK) begin
          now_hour = it.set_hour[HOUR_W-1:0];
          now_min  = it.set_minute[MIN_W-1:0];
          now_sec  = it.set_second[SEC_W-1:0];
          now_pm   = it.set_hour > 7'(NOON_HOUR);
        end else begin
          alm_hour = it.set_hour[HOUR_W-1:0];
          alm_min  = it.set_minute[MIN_W-1:0];
          alm_sec  = it.set_second[SEC_W-1:0];
        end
      end
      default: alarm_on = 1'b0;
    endcase
    r.hour         = now_hour;
    r.minute       = now_min;
    r.second       = now_sec;
    r.pm           = now_pm;
    r.alarm_active = alarm_on;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Offer one item, wait for the transfer, then record its expected result.
  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    result_t predicted;
    while (!steady && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= {3'b000, it.set_second, it.set_minute, it.set_hour};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_step(it);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drain the block, then write ticks_per_second.
  task automatic write_tps(input logic [TPS_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid     <= 1'b0;
    ticks_per_sec  = value;
  endtask

  task automatic send_random_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.set_hour   = 7'($urandom_range(23));
    it.set_minute = 7'($urandom_range(59));
    it.set_second = 7'($urandom_range(59));
    if (pick < 55) begin
      it.cmd = CMD_TICK;
    end else if (pick < 65) begin
      // park the clock just short of a carry
      it.cmd = CMD_SET_CLOCK;
      case ($urandom_range(2))
        0: it.set_hour = 7'(LAST_HOUR);
        1: it.set_hour = 7'(NOON_HOUR);
        default: ;
      endcase
      if ($urandom_range(1)) it.set_minute = 7'(LAST_MINUTE);
      it.set_second = 7'($urandom_range(55, 59));
    end else if (pick < 73) begin
      // aim the alarm a few seconds ahead of the clock
      it.cmd        = CMD_SET_ALARM;
      it.set_hour   = 7'(now_hour);
      it.set_minute = 7'(now_min);
      it.set_second = 7'((now_sec + $urandom_range(1, 5)) % 60);
    end else if (pick < 81) begin
      it.cmd = CMD_SILENCE;
    end else if (pick < 93) begin
      it.cmd        = $urandom_range(1) ? CMD_SET_CLOCK : CMD_SET_ALARM;
      it.set_hour   = 7'($urandom_range(127));
      it.set_minute = 7'($urandom_range(127));
      it.set_second = 7'($urandom_range(127));
    end else begin
      it.cmd = cmd_t'($urandom_range(3));
    end
    send_item(it, 1'b0, '0);
  endtask

  // Receiver: random back-pressure, one long hold once traffic is flowing.
  always @(posedge clk) begin
    if (squeeze_left != 0) begin
      squeeze_left--;
      m_tready <= 1'b0;
    end else if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
      squeeze_done = 1'b1;
      squeeze_left = SQUEEZE_LEN;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, actual %h", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("hour", want.hour, m_tdata[4:0]);
        check_field("minute", want.minute, m_tdata[10:5]);
        check_field("second", want.second, m_tdata[16:11]);
        check_field("pm", want.pm, m_tdata[17]);
        check_field("alarm_active", want.alarm_active, m_tdata[18]);
        check_field("set_valid", want.set_valid, m_tdata[19]);
        check_field("padding", 0, m_tdata[23:20]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [TPS_W-1:0] phase_tps[8];
    item_t            it;
    phase_tps = '{16'd1, 16'd65535, 16'd5, 16'd1, 16'd0, 16'd3, 16'd65535, 16'd2};

    // hour, minute, second, pm, alarm, valid in each expected result
    dir_table.push_back('{ROW_ITEM, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd0, 1'b1,
                          '{5'd0, 6'd0, 6'd1, 1'b0, 1'b0, 1'b1}});
    dir_table.push_back('{ROW_ITEM, CMD_SET_CLOCK, 7'd23, 7'd59, 7'd59, 16'd0, 1'b1,
                          '{5'd23, 6'd59, 6'd59, 1'b1, 1'b0, 1'b1}});
    // midnight wrap lands on the reset alarm time
    dir_table.push_back('{ROW_ITEM, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd0, 1'b1,
                          '{5'd0, 6'd0, 6'd0, 1'b0, 1'b1, 1'b1}});
    dir_table.push_back('{ROW_ITEM, CMD_SILENCE, 7'd0, 7'd0, 7'd0, 16'd0, 1'b1,
                          '{5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b1}});
    dir_table.push_back('{ROW_ITEM, CMD_SILENCE, 7'd127, 7'd127, 7'd127, 16'd0, 1'b1,
                          '{5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b1}});
    dir_table.push_back('{ROW_ITEM, CMD_SET_CLOCK, 7'd24, 7'd0, 7'd0, 16'd0, 1'b1,
                          '{5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0}});
    dir_table.push_back('{ROW_ITEM, CMD_SET_ALARM, 7'd0, 7'd60, 7'd0, 16'd0, 1'b1,
                          '{5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0}});
    dir_table.push_back('{ROW_ITEM, CMD_SET_CLOCK, 7'd0, 7'd0, 7'd60, 16'd0, 1'b1,
                          '{5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0}});
    dir_table.push_back('{ROW_ITEM, CMD_SET_ALARM, 7'd127, 7'd127, 7'd127, 16'd0, 1'b1,
                          '{5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0}});
    dir_table.push_back('{ROW_ITEM, CMD_SET_ALARM, 7'd23, 7'd59, 7'd59, 16'd0, 1'b0, '0});
    dir_table.push_back('{ROW_ITEM, CMD_SET_CLOCK, 7'd11, 7'd59, 7'd58, 16'd0, 1'b1,
                          '{5'd11, 6'd59, 6'd58, 1'b0, 1'b0, 1'b1}});
    dir_table.push_back('{ROW_ITEM, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd0, 1'b0, '0});
    dir_table.push_back('{ROW_ITEM, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd0, 1'b1,
                          '{5'd12, 6'd0, 6'd0, 1'b1, 1'b0, 1'b1}});
    dir_table.push_back('{ROW_ITEM, CMD_SET_CLOCK, 7'd23, 7'd59, 7'd58, 16'd0, 1'b0, '0});
    dir_table.push_back('{ROW_ITEM, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd0, 1'b0, '0});
    dir_table.push_back('{ROW_ITEM, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd0, 1'b0, '0});
    // a set leaves the sticky flag alone
    dir_table.push_back('{ROW_ITEM, CMD_SET_CLOCK, 7'd12, 7'd0, 7'd0, 16'd0, 1'b0, '0});
    dir_table.push_back('{ROW_ITEM, CMD_SILENCE, 7'd0, 7'd0, 7'd0, 16'd0, 1'b0, '0});
    dir_table.push_back('{ROW_CONFIG, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd0, 1'b0, '0});
    dir_table.push_back('{ROW_ITEM, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd0, 1'b0, '0});
    dir_table.push_back('{ROW_ITEM, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd0, 1'b0, '0});
    dir_table.push_back('{ROW_CONFIG, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd6, 1'b0, '0});
    repeat (4) dir_table.push_back('{ROW_ITEM, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd0, 1'b0, '0});
    // drop the threshold below the running count
    dir_table.push_back('{ROW_CONFIG, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd2, 1'b0, '0});
    dir_table.push_back('{ROW_ITEM, CMD_TICK, 7'd0, 7'd0, 7'd0, 16'd0, 1'b0, '0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CONFIG) begin
        write_tps(dir_table[i].tps);
      end else begin
        it.cmd        = dir_table[i].cmd;
        it.set_hour   = dir_table[i].h;
        it.set_minute = dir_table[i].m;
        it.set_second = dir_table[i].s;
        send_item(it, dir_table[i].typed, dir_table[i].want);
      end
    end

    foreach (phase_tps[p]) begin
      write_tps(phase_tps[p]);
      steady = (p == 3);
      repeat (PHASE_ITEMS) send_random_item();
      steady = 1'b0;
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+sv
sv/tod_pkg.sv
sv/tod_engine.sv
sv/time_of_day_clock_with_alarm_unit.sv
sv/tod_checker.sv
tb/sv/time_of_day_clock_with_alarm_unit_tb.sv
